// ===== rtl/cxs_pkg.sv =====
// ----------------------------------------------------------------------------
// cxs_pkg: shared types and constants for the xy to srgb converter
// payload structs, fixed coefficients and the gamma threshold builder
// ----------------------------------------------------------------------------
package cxs_pkg;

    localparam int COORD_W  = 16;
    localparam int CHAN_W   = 8;
    localparam int ONE_CODE = 65535;
    localparam int Y_FLOOR  = 66;
    localparam int LEVELS   = 256;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } out_t;

    // matrix coefficients in units of 1e-4, sign folded in
    localparam longint C4_RX =  32406;
    localparam longint C4_RY = -15372;
    localparam longint C4_RZ = -4986;
    localparam longint C4_GX = -9689;
    localparam longint C4_GY =  18758;
    localparam longint C4_GZ =  415;
    localparam longint C4_BX =  557;
    localparam longint C4_BY = -2040;
    localparam longint C4_BZ =  10570;

    // round(|c| * 2^frac) with ties up, sign reapplied
    function automatic longint coef_q(longint c4, int frac);
        longint mag;
        longint q;
        mag = (c4 < 0) ? -c4 : c4;
        q = (mag * (64'sd1 <<< frac) + 5000) / 10000;
        return (c4 < 0) ? -q : q;
    endfunction

    // smallest index whose encoded level reaches k
    function automatic longint gamma_threshold(int k, longint full);
        longint lin_max;
        longint t_lin;
        longint t_pow;
        real    base;
        real    p;
        if (k == 0) begin
            return 0;
        end
        lin_max = (31308 * full) / 10000000;
        t_lin   = (10 * full * k + 32945) / 32946;
        if (t_lin <= lin_max) begin
            return t_lin;
        end
        base  = (1000.0 * k + 14025.0) / 269025.0;
        p     = base ** 2.4;
        t_pow = longint'($ceil(p * full));
        if (t_pow < lin_max + 1) begin
            t_pow = lin_max + 1;
        end
        if (t_pow > full) begin
            t_pow = full;
        end
        return t_pow;
    endfunction

endpackage

// ===== rtl/cxs_div.sv =====
// ----------------------------------------------------------------------------
// cxs_div: pipelined fixed point divider
// forms X = x/y and Z = (1-x-y)/y with floor rounding, 4 quotient bits per stage
// ----------------------------------------------------------------------------
module cxs_div
    import cxs_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_vld,
    input  in_t                             in_data,
    output logic                            out_vld,
    output logic signed [COORD_W+FRACTION_BITS:0] xq,
    output logic signed [COORD_W+FRACTION_BITS:0] zq
);

    localparam int NW   = COORD_W + FRACTION_BITS;
    localparam int RW   = COORD_W + 1;
    localparam int BPS  = 4;
    localparam int NSTG = (NW + BPS - 1) / BPS;

    logic [NSTG:0]      vld_reg;
    logic [NW-1:0]      wx_reg  [NSTG+1];
    logic [NW-1:0]      wz_reg  [NSTG+1];
    logic [RW-1:0]      rx_reg  [NSTG+1];
    logic [RW-1:0]      rz_reg  [NSTG+1];
    logic [COORD_W-1:0] d_reg   [NSTG+1];
    logic               neg_reg [NSTG+1];

    logic                    out_vld_reg;
    logic signed [NW:0]      xq_reg;
    logic signed [NW:0]      zq_reg;

    // prep: floor y, form |1-x-y| and its sign
    logic [COORD_W-1:0]   y_fl;
    logic signed [COORD_W+2:0] zn;
    logic [COORD_W-1:0]   zmag;

    always_comb begin
        y_fl = (in_data.y_coord < COORD_W'(Y_FLOOR)) ? COORD_W'(Y_FLOOR) : in_data.y_coord;
        zn   = (COORD_W+3)'(ONE_CODE) - (COORD_W+3)'(in_data.x_coord) - (COORD_W+3)'(y_fl);
        zmag = zn[COORD_W+2] ? COORD_W'(-zn) : COORD_W'(zn);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg[0]  <= {in_data.x_coord, {FRACTION_BITS{1'b0}}};
            wz_reg[0]  <= {zmag, {FRACTION_BITS{1'b0}}};
            rx_reg[0]  <= '0;
            rz_reg[0]  <= '0;
            d_reg[0]   <= y_fl;
            neg_reg[0] <= zn[COORD_W+2];
        end
    end

    for (genvar i = 1; i <= NSTG; i++) begin : g_stg
        logic [NW-1:0] wx_next;
        logic [NW-1:0] wz_next;
        logic [RW-1:0] rx_next;
        logic [RW-1:0] rz_next;

        // restoring steps, one quotient bit each
        always_comb begin
            wx_next = wx_reg[i-1];
            wz_next = wz_reg[i-1];
            rx_next = rx_reg[i-1];
            rz_next = rz_reg[i-1];
            for (int j = 0; j < BPS; j++) begin
                if ((i - 1) * BPS + j < NW) begin
                    rx_next = {rx_next[RW-2:0], wx_next[NW-1]};
                    wx_next = {wx_next[NW-2:0], 1'b0};
                    if (rx_next >= {1'b0, d_reg[i-1]}) begin
                        rx_next    = rx_next - {1'b0, d_reg[i-1]};
                        wx_next[0] = 1'b1;
                    end
                    rz_next = {rz_next[RW-2:0], wz_next[NW-1]};
                    wz_next = {wz_next[NW-2:0], 1'b0};
                    if (rz_next >= {1'b0, d_reg[i-1]}) begin
                        rz_next    = rz_next - {1'b0, d_reg[i-1]};
                        wz_next[0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                wx_reg[i]  <= wx_next;
                wz_reg[i]  <= wz_next;
                rx_reg[i]  <= rx_next;
                rz_reg[i]  <= rz_next;
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // sign fix: negative quotient rounds toward minus infinity
    logic signed [NW:0] zq_next;

    always_comb begin
        zq_next = {1'b0, wz_reg[NSTG]};
        if (neg_reg[NSTG]) begin
            zq_next = -({1'b0, wz_reg[NSTG]} + (NW+1)'(rz_reg[NSTG] != '0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xq_reg <= {1'b0, wx_reg[NSTG]};
            zq_reg <= zq_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign xq      = xq_reg;
    assign zq      = zq_reg;

endmodule

// ===== rtl/cxs_matrix.sv =====
// ----------------------------------------------------------------------------
// cxs_matrix: xyz to linear rgb matrix and index reduction
// multiply, sum, clamp and scale each channel to a gamma index
// ----------------------------------------------------------------------------
module cxs_matrix
    import cxs_pkg::*;
#(
    parameter int FRACTION_BITS    = 16,
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic signed [COORD_W+FRACTION_BITS:0] xq,
    input  logic signed [COORD_W+FRACTION_BITS:0] zq,
    output logic                                  out_vld,
    output logic [GAMMA_INDEX_BITS-1:0]           idx [3]
);

    localparam int F   = FRACTION_BITS;
    localparam int IB  = GAMMA_INDEX_BITS;
    localparam int QW  = COORD_W + F + 1;
    localparam int CW  = F + 3;
    localparam int PW  = QW + CW;
    localparam int SW  = PW + 2;
    localparam int PRW = 2 * F + IB;

    localparam longint KX [3] = '{coef_q(C4_RX, F), coef_q(C4_GX, F), coef_q(C4_BX, F)};
    localparam longint KZ [3] = '{coef_q(C4_RZ, F), coef_q(C4_GZ, F), coef_q(C4_BZ, F)};
    localparam longint KY [3] = '{coef_q(C4_RY, F), coef_q(C4_GY, F), coef_q(C4_BY, F)};

    localparam logic [IB-1:0] FULL = '1;

    logic [3:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        localparam logic signed [CW-1:0] CX = CW'(KX[c]);
        localparam logic signed [CW-1:0] CZ = CW'(KZ[c]);
        localparam logic signed [SW-1:0] C0 = SW'(KY[c] * (64'sd1 <<< F));

        logic signed [PW-1:0]  px_reg;
        logic signed [PW-1:0]  pz_reg;
        logic signed [SW-1:0]  sum_reg;
        logic [PRW-1:0]        prod_reg;
        logic                  zero_reg;
        logic                  one_reg;
        logic [IB-1:0]         idx_reg;
        logic                  is_zero;
        logic                  is_one;
        logic [PRW:0]          rnd;

        always_comb begin
            is_zero = sum_reg[SW-1] || (sum_reg == '0);
            is_one  = !sum_reg[SW-1] && (|sum_reg[SW-2:2*F]);
            rnd     = {1'b0, prod_reg} + ((PRW+1)'(1) << (2 * F - 1));
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                px_reg   <= xq * CX;
                pz_reg   <= zq * CZ;
                sum_reg  <= SW'(px_reg) + SW'(pz_reg) + C0;
                zero_reg <= is_zero;
                one_reg  <= is_one;
                prod_reg <= PRW'(sum_reg[2*F-1:0]) * PRW'(FULL);
                if (zero_reg) begin
                    idx_reg <= '0;
                end else if (one_reg) begin
                    idx_reg <= FULL;
                end else begin
                    idx_reg <= rnd[2*F+IB-1:2*F];
                end
            end
        end

        assign idx[c] = idx_reg;
    end

    assign out_vld = vld_reg[3];

endmodule

// ===== rtl/cxs_gamma.sv =====
// ----------------------------------------------------------------------------
// cxs_gamma: srgb gamma encoder
// binary search over the level thresholds, one result bit per stage
// ----------------------------------------------------------------------------
module cxs_gamma
    import cxs_pkg::*;
#(
    parameter int GAMMA_INDEX_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [GAMMA_INDEX_BITS-1:0] idx [3],
    output logic                        out_vld,
    output out_t                        out_data
);

    localparam int IB = GAMMA_INDEX_BITS;

    typedef logic [IB-1:0] thr_tab_t [LEVELS];

    function automatic thr_tab_t build_tab();
        thr_tab_t t;
        longint   full;
        full = (64'sd1 <<< IB) - 1;
        for (int k = 0; k < LEVELS; k++) begin
            t[k] = IB'(gamma_threshold(k, full));
        end
        return t;
    endfunction

    localparam thr_tab_t THR = build_tab();

    logic [CHAN_W:0]    vld_a;
    logic [IB-1:0]      idx_a [CHAN_W+1][3];
    logic [CHAN_W-1:0]  lvl_a [CHAN_W+1][3];

    assign vld_a[0] = in_vld;

    for (genvar c = 0; c < 3; c++) begin : g_in
        assign idx_a[0][c] = idx[c];
        assign lvl_a[0][c] = '0;
    end

    for (genvar j = 1; j <= CHAN_W; j++) begin : g_stg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_a[j] <= 1'b0;
            end else if (en) begin
                vld_a[j] <= vld_a[j-1];
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_ch
            logic [CHAN_W-1:0] cand;
            assign cand = lvl_a[j-1][c] | (CHAN_W'(1) << (CHAN_W - j));

            always_ff @(posedge aclk) begin
                if (en) begin
                    idx_a[j][c] <= idx_a[j-1][c];
                    lvl_a[j][c] <= (THR[cand] <= idx_a[j-1][c]) ? cand : lvl_a[j-1][c];
                end
            end
        end
    end

    assign out_vld        = vld_a[CHAN_W];
    assign out_data.red   = lvl_a[CHAN_W][0];
    assign out_data.green = lvl_a[CHAN_W][1];
    assign out_data.blue  = lvl_a[CHAN_W][2];

endmodule

// ===== rtl/cie_xy_to_srgb_gamma.sv =====
// ----------------------------------------------------------------------------
// cie_xy_to_srgb_gamma: cie 1931 xy chromaticity to gamma-encoded srgb
// converts one xy pair per cycle, unless the output stalls, into 8-bit d65 red, green and blue
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request carries x_coord and y_coord, unsigned 0.16
//   m_ channel: one request carries red, green and blue for each input
//   the divider, the matrix and the gamma search run in that order, each
//   pipelined; one request per cycle sustained unless the output stalls
//   the divider retires 4 quotient bits per stage, the gamma encoder one
//   level bit per stage, so depth follows FRACTION_BITS and the 256 levels
//   every stage holds while the output request waits: s_ready drops as soon
//   as m_valid is high and m_ready is low, and nothing is lost or repeated
//   reset clears every valid bit; data registers keep no reset
//   y codes below 66 act as 66; out of gamut channels clip to 0 or 255
// ----------------------------------------------------------------------------
module cie_xy_to_srgb_gamma
    import cxs_pkg::*;
#(
    parameter int GAMMA_INDEX_BITS = 12,
    parameter int FRACTION_BITS    = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // single pipeline enable: advance unless the output request is stuck
    logic en;

    logic                                  div_vld;
    logic signed [COORD_W+FRACTION_BITS:0] xq;
    logic signed [COORD_W+FRACTION_BITS:0] zq;

    logic                        mat_vld;
    logic [GAMMA_INDEX_BITS-1:0] idx [3];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage group 1: X and Z quotients
    cxs_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid),
        .in_data (s_data),
        .out_vld (div_vld),
        .xq      (xq),
        .zq      (zq)
    );

    // stage group 2: matrix, clamp and index scaling
    cxs_matrix #(
        .FRACTION_BITS    (FRACTION_BITS),
        .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (div_vld),
        .xq      (xq),
        .zq      (zq),
        .out_vld (mat_vld),
        .idx     (idx)
    );

    // stage group 3: gamma level search, last stage is the output register
    cxs_gamma #(
        .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_gamma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (mat_vld),
        .idx      (idx),
        .out_vld  (m_valid),
        .out_data (m_data)
    );

    // nothing leaves the pipe right after reset
    a_reset_empty: assert property (@(posedge aclk) $rose(aresetn) |-> !m_valid)
        else $error("output valid right after reset");

    // a held output must back-pressure the input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    // a ready sink never blocks the input
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked with sink ready");

endmodule
